/* rtl/core/anbs_pkg.sv */
`default_nettype none

package anbs_pkg;

  localparam int unsigned WinBytes = 5;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    PH_AWAIT = 3'b001,
    PH_UNIT  = 3'b010,
    PH_ERROR = 3'b100
  } phase_t;

  localparam logic [2:0] CodeNone  = 3'd0;
  localparam logic [2:0] CodeShort = 3'd3;
  localparam logic [2:0] CodeLong  = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       unit_first;
    logic       unit_last;
    logic [2:0] code_length;
    logic       stream_error;
    logic       run_end;
  } out_item_t;

  typedef logic [WinBytes-1:0][7:0] win_t;

  // One queued job: a window to decide, either its head only or all of it.
  typedef struct packed {
    win_t       win;
    logic [2:0] avail;
    logic       flush;
    logic [1:0] skip;
    phase_t     phase;
  } job_t;

  typedef struct packed {
    logic       first;
    logic       last;
    logic [2:0] len;
    logic       err;
    logic [1:0] skip;
    phase_t     phase;
  } head_t;

  function automatic logic [2:0] code_at(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3,
                                         input logic [2:0] avail);
    logic [2:0] len;
    len = CodeNone;
    if (avail >= 3'd3 && b0 == 8'd0 && b1 == 8'd0) begin
      if (b2 == 8'd1) begin
        len = CodeShort;
      end else if (avail >= 3'd4 && b2 == 8'd0 && b3 == 8'd1) begin
        len = CodeLong;
      end
    end
    return len;
  endfunction

  // Decide the oldest byte of the window, avail >= 1.
  function automatic head_t decide_head(input win_t w, input logic [2:0] avail,
                                        input logic [1:0] skip, input phase_t phase);
    head_t h;
    h.first = 1'b0;
    h.len   = CodeNone;
    h.err   = 1'b0;
    h.skip  = skip;
    h.phase = phase;
    if (skip != 2'd0) begin
      h.skip = skip - 2'd1;
    end else begin
      h.len = code_at(w[0], w[1], w[2], w[3], avail);
      if (h.len == CodeNone && phase != PH_UNIT) begin
        h.err = 1'b1;
      end else if (h.len != CodeNone) begin
        h.first = 1'b1;
        h.skip  = h.len[1:0] - 2'd1;
        h.phase = PH_UNIT;
      end
    end
    if (h.skip != 2'd0) begin
      h.last = 1'b0;
    end else if (avail >= 3'd2) begin
      h.last = code_at(w[1], w[2], w[3], w[4], avail - 3'd1) != CodeNone;
    end else begin
      h.last = 1'b1;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/anbs_front.sv */
`default_nettype none

module anbs_front
  import anbs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_fire,
  input  wire in_item_t in_item,
  output logic          push,
  output job_t          push_job
);

  logic [3:0][7:0] look_r, look_nxt;
  logic [2:0]      held_r, held_nxt;
  phase_t          phase_r, phase_nxt;
  logic [1:0]      skip_r, skip_nxt;

  win_t       win;
  logic [2:0] avail;
  head_t      head;

  always_comb begin
    for (int i = 0; i < WinBytes; i++) begin
      if (3'(i) < held_r) begin
        win[i] = look_r[i];
      end else if (3'(i) == held_r) begin
        win[i] = in_item.data_byte;
      end else begin
        win[i] = 8'd0;
      end
    end
  end

  assign avail = held_r + 3'd1;
  assign head  = decide_head(win, avail, skip_r, phase_r);

  always_comb begin
    look_nxt       = look_r;
    held_nxt       = held_r;
    phase_nxt      = phase_r;
    skip_nxt       = skip_r;
    push           = 1'b0;
    push_job.win   = win;
    push_job.avail = avail;
    push_job.flush = in_item.final_byte;
    push_job.skip  = skip_r;
    push_job.phase = phase_r;
    if (in_fire) begin
      if (phase_r == PH_ERROR) begin
        // drop bytes until the end of the stream
        if (in_item.final_byte) begin
          held_nxt  = 3'd0;
          phase_nxt = PH_AWAIT;
          skip_nxt  = 2'd0;
        end
      end else if (in_item.final_byte) begin
        push      = 1'b1;
        held_nxt  = 3'd0;
        phase_nxt = PH_AWAIT;
        skip_nxt  = 2'd0;
      end else if (avail == 3'(WinBytes)) begin
        push = 1'b1;
        if (head.err) begin
          phase_nxt = PH_ERROR;
          held_nxt  = 3'd0;
        end else begin
          phase_nxt = head.phase;
          skip_nxt  = head.skip;
          for (int i = 0; i < 4; i++) begin
            look_nxt[i] = win[i+1];
          end
        end
      end else begin
        look_nxt = win[3:0];
        held_nxt = avail;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 3'd0;
      phase_r <= PH_AWAIT;
      skip_r  <= 2'd0;
    end else begin
      held_r  <= held_nxt;
      phase_r <= phase_nxt;
      skip_r  <= skip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    look_r <= look_nxt;
  end

endmodule

`default_nettype wire

/* rtl/core/anbs_queue.sv */
`default_nettype none

module anbs_queue
  import anbs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output logic      full,
  output logic      empty,
  output job_t      head_job
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  job_t            mem_r [QueueDepth];
  logic [PtrW-1:0] wr_r, rd_r;
  logic [PtrW:0]   count_r;

  assign full     = count_r == (PtrW+1)'(QueueDepth);
  assign empty    = count_r == '0;
  assign head_job = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PtrW'(QueueDepth - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/anbs_back.sv */
`default_nettype none

module anbs_back
  import anbs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic job_ready,
  input  wire job_t job,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_data
);

  logic [2:0] pos_r;
  logic [1:0] skip_r;
  phase_t     phase_r;
  logic       valid_r;
  out_item_t  data_r;

  win_t       win;
  logic [2:0] avail;
  logic [1:0] cur_skip;
  phase_t     cur_phase;
  head_t      head;
  logic       step;
  logic       done;
  out_item_t  res;

  // first step of a job takes its state from the job, later steps carry their own
  assign cur_skip  = (pos_r == 3'd0) ? job.skip : skip_r;
  assign cur_phase = (pos_r == 3'd0) ? job.phase : phase_r;
  assign win       = job.win >> {pos_r, 3'b000};
  assign avail     = job.avail - pos_r;
  assign head      = decide_head(win, avail, cur_skip, cur_phase);

  assign step = job_ready && (!valid_r || !out_stall);
  assign done = head.err || !job.flush || (avail == 3'd1);
  assign pop  = step && done;

  always_comb begin
    if (head.err) begin
      res              = '0;
      res.stream_error = 1'b1;
      res.run_end      = 1'b1;
    end else begin
      res.out_byte     = win[0];
      res.unit_first   = head.first;
      res.unit_last    = head.last;
      res.code_length  = head.len;
      res.stream_error = 1'b0;
      res.run_end      = done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 3'd0;
      skip_r  <= 2'd0;
      phase_r <= PH_AWAIT;
      valid_r <= 1'b0;
    end else begin
      if (step) begin
        valid_r <= 1'b1;
        if (done) begin
          pos_r <= 3'd0;
        end else begin
          pos_r   <= pos_r + 3'd1;
          skip_r  <= head.skip;
          phase_r <= head.phase;
        end
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

/* rtl/core/annexb_nal_unit_splitter.sv */
`default_nettype none
// Channel   Ports                          Beat
// input     in_valid, in_stall, in_data    one stream byte, final flag
// result    out_valid, out_stall, out_data one re-emitted byte or an error
//
// A byte is taken every cycle while the job queue has room; the front holds
// up to four bytes back and pushes one job per byte once five are known.
// A final byte flushes the window: up to five results, one per unstalled cycle
// from the back end, through one output register.
// Reset (rst_n low, synchronous) empties window, queue and output register.
// out_stall holds the back end; the two-entry queue then fills and in_stall rises.

module annexb_nal_unit_splitter
  import anbs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  job_t push_job;
  job_t head_job;

  assign in_stall = q_full;

  anbs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_valid && !q_full),
    .in_item  (in_data),
    .push     (push),
    .push_job (push_job)
  );

  anbs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head_job (head_job)
  );

  anbs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_ready (!q_empty),
    .job       (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* sim/testbench.sv */
module testbench;
  import anbs_pkg::*;

  typedef struct packed {
    in_item_t beat;
    logic     drain;
  } stim_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  annexb_nal_unit_splitter uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Splitter shadow state: held window bytes, parse phase, start code bytes to skip.
  logic [7:0]  held_b [0:3];
  logic [7:0]  win_b  [0:4];
  int unsigned held_n;
  phase_t      phase_s;
  int unsigned skip_n;

  out_item_t   expected_beats [$];
  stim_t       stream_q [$];
  logic [7:0]  sbuf [$];
  int          queued_n = 0;
  int          accepted_n = 0;
  int          fail_count = 0;
  int          in_gap = 0;
  int          in_calm = 0;
  int          out_hold = 0;
  int          out_calm = 0;

  task automatic clear_stream();
    for (int i = 0; i < 4; i++) held_b[i] = 8'h00;
    held_n = 0;
    phase_s = PH_AWAIT;
    skip_n = 0;
  endtask

  function automatic logic [2:0] start_code_len(input int at, input int avail);
    logic [2:0] len;
    len = CodeNone;
    if (avail >= 3 && win_b[at] == 8'h00 && win_b[at+1] == 8'h00) begin
      if (win_b[at+2] == 8'h01) begin
        len = CodeShort;
      end else if (avail >= 4 && win_b[at+2] == 8'h00 && win_b[at+3] == 8'h01) begin
        len = CodeLong;
      end
    end
    return len;
  endfunction

  // Decide the window byte at position at, with avail bytes left from there.
  task automatic decide_byte(input int at, input int avail, output bit ok,
                             output out_item_t r);
    logic [2:0] len;
    r = '0;
    ok = 1'b1;
    len = CodeNone;
    if (skip_n > 0) begin
      skip_n--;
    end else begin
      len = start_code_len(at, avail);
      if (len == CodeNone && phase_s != PH_UNIT) begin
        ok = 1'b0;
      end else if (len != CodeNone) begin
        r.unit_first = 1'b1;
        skip_n = len - 3'd1;
        phase_s = PH_UNIT;
      end
    end
    r.out_byte = win_b[at];
    r.code_length = len;
    if (skip_n > 0) begin
      r.unit_last = 1'b0;
    end else if (avail >= 2) begin
      r.unit_last = start_code_len(at + 1, avail - 1) != CodeNone;
    end else begin
      r.unit_last = 1'b1;
    end
  endtask

  task automatic predict_split(input in_item_t it);
    out_item_t batch [0:4];
    out_item_t r;
    out_item_t err_r;
    bit        ok;
    int        n;
    int        k;
    err_r = '0;
    err_r.stream_error = 1'b1;
    k = 0;
    if (phase_s == PH_ERROR) begin
      // drop everything until the stream ends
      if (it.final_byte) clear_stream();
    end else begin
      for (int i = 0; i < held_n; i++) win_b[i] = held_b[i];
      win_b[held_n] = it.data_byte;
      n = held_n + 1;
      if (it.final_byte) begin
        for (int s = 0; s < n; s++) begin
          decide_byte(s, n - s, ok, r);
          if (!ok) begin
            batch[0] = err_r;
            k = 1;
            break;
          end
          batch[k] = r;
          k++;
        end
        clear_stream();
      end else if (n == 5) begin
        decide_byte(0, 5, ok, r);
        if (!ok) begin
          batch[0] = err_r;
          k = 1;
          phase_s = PH_ERROR;
          held_n = 0;
          for (int i = 0; i < 4; i++) held_b[i] = 8'h00;
        end else begin
          batch[0] = r;
          k = 1;
          for (int i = 0; i < 4; i++) held_b[i] = win_b[i+1];
          held_n = 4;
        end
      end else begin
        for (int i = 0; i < n; i++) held_b[i] = win_b[i];
        held_n = n;
      end
      for (int i = 0; i < k; i++) begin
        r = batch[i];
        r.run_end = (i == k - 1);
        expected_beats.push_back(r);
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Driver: advance to the next queued beat once the current one is taken.
  always @(posedge clk) begin
    stim_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_split(in_data);
        accepted_n++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (stream_q.size() != 0 &&
                     !(stream_q[0].drain && expected_beats.size() != 0)) begin
          nxt = stream_q.pop_front();
          in_data <= nxt.beat;
          in_valid <= 1'b1;
          if (in_calm > 0) begin
            in_calm--;
            in_gap = 0;
          end else begin
            if ($urandom_range(0, 99) == 0) in_calm = $urandom_range(20, 60);
            in_gap = pick_gap();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken beat against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    int r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat: byte=%h first=%b last=%b len=%0d err=%b end=%b",
                   $time, out_data.out_byte, out_data.unit_first, out_data.unit_last,
                   out_data.code_length, out_data.stream_error, out_data.run_end);
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          if (out_data !== want) begin
            $display("%0t: beat mismatch: expected byte=%h first=%b last=%b len=%0d err=%b end=%b",
                     $time, want.out_byte, want.unit_first, want.unit_last,
                     want.code_length, want.stream_error, want.run_end);
            $display("%0t:                actual   byte=%h first=%b last=%b len=%0d err=%b end=%b",
                     $time, out_data.out_byte, out_data.unit_first, out_data.unit_last,
                     out_data.code_length, out_data.stream_error, out_data.run_end);
            fail_count++;
          end
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else if (out_calm > 0) begin
        out_calm--;
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r == 0) begin
          out_calm = $urandom_range(20, 60);
          out_stall <= 1'b0;
        end else if (r < 70) begin
          out_stall <= 1'b0;
        end else if (r < 95) begin
          out_hold = $urandom_range(0, 2);
          out_stall <= 1'b1;
        end else begin
          out_hold = $urandom_range(8, 40);
          out_stall <= 1'b1;
        end
      end
    end
  end

  task automatic add_bytes(input logic [63:0] bytes, input int cnt);
    for (int i = 0; i < cnt; i++) sbuf.push_back(bytes[8*(cnt-1-i) +: 8]);
  endtask

  task automatic add_start_code();
    if ($urandom_range(0, 1) == 1) add_bytes(64'h0000_0001, 4);
    else add_bytes(64'h00_0001, 3);
  endtask

  // Move the buffered bytes into the beat queue, final flag on the last.
  task automatic queue_stream(input bit drain);
    stim_t st;
    for (int i = 0; i < sbuf.size(); i++) begin
      st.beat.data_byte = sbuf[i];
      st.beat.final_byte = (i == sbuf.size() - 1);
      st.drain = drain && (i == 0);
      stream_q.push_back(st);
      queued_n++;
    end
    sbuf.delete();
  endtask

  task automatic gen_good_stream();
    int body;
    int r;
    add_start_code();
    body = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
    for (int i = 0; i < body; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12) add_start_code();
      else if (r < 35) sbuf.push_back(8'h00);
      else if (r < 42) sbuf.push_back(8'h01);
      else sbuf.push_back(8'($urandom));
    end
  endtask

  task automatic gen_noise_stream();
    int cnt;
    case ($urandom_range(0, 3))
      0: begin
        cnt = $urandom_range(1, 2);
        for (int i = 0; i < cnt; i++)
          sbuf.push_back(($urandom_range(0, 2) != 0) ? 8'h00 : 8'($urandom));
      end
      1: begin
        sbuf.push_back(8'($urandom_range(1, 255)));
        cnt = $urandom_range(0, 6);
        for (int i = 0; i < cnt; i++) sbuf.push_back(8'($urandom));
      end
      2: begin
        add_bytes(64'h00_0000_0001, 5);
        cnt = $urandom_range(0, 3);
        for (int i = 0; i < cnt; i++) sbuf.push_back(8'($urandom));
      end
      default: begin
        add_bytes(64'h00_0002, 3);
        cnt = $urandom_range(0, 4);
        for (int i = 0; i < cnt; i++) sbuf.push_back(8'($urandom));
      end
    endcase
  endtask

  initial begin
    int streams;
    clear_stream();

    // 4-byte and 3-byte codes, a unit of only a start code at the end
    add_bytes(64'h0000_0001_FF00_0001, 8);
    add_bytes(64'h00_0001, 3);
    queue_stream(1'b0);
    // too short, after a drain of everything in flight
    add_bytes(64'h00, 1);
    queue_stream(1'b1);
    add_bytes(64'h0000, 2);
    queue_stream(1'b0);
    // no leading start code; the rest is dropped up to the final byte
    add_bytes(64'hA5_0000_01FF_807F, 7);
    queue_stream(1'b0);

    streams = 0;
    while (queued_n < 320) begin
      if ($urandom_range(0, 99) < 85) gen_good_stream();
      else gen_noise_stream();
      queue_stream(streams % 12 == 11);
      streams++;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_n < queued_n) @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0 && expected_beats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
